FILE: rtl/mkde_pkg.sv
package mkde_pkg;

   localparam int ROWS      = 4;
   localparam int COLUMNS   = 4;
   localparam int IN_COLS   = 4;
   localparam int SCAN_COLS = (COLUMNS < IN_COLS) ? COLUMNS : IN_COLS;
   localparam int KEY_TOTAL = ROWS * COLUMNS;
   localparam int KEY_W     = 4;
   localparam int ROW_W     = 2;
   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

   localparam logic [1:0] EV_PRESS   = 2'd0;
   localparam logic [1:0] EV_LONG    = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGPRESS = 2'd2;

   typedef struct packed {
      logic [ROW_W-1:0]   row_index;
      logic [IN_COLS-1:0] column_levels;
   } req_word_type;

   typedef struct packed {
      logic [KEY_W-1:0] key_index;
      logic [1:0]       event_code;
      logic             last_event;
   } rsp_word_type;

   typedef struct packed {
      logic             enabled;
      logic [CNT_W-1:0] debounce_count;
      logic [CNT_W-1:0] longpress_count;
   } cfg_type;

   // one classified row scan: events still to be sent, per column
   typedef struct packed {
      logic [ROW_W-1:0]               row;
      logic [SCAN_COLS-1:0]           ev_mask;
      logic [SCAN_COLS-1:0][1:0]      codes;
   } scan_ev_type;

endpackage

FILE: rtl/mkde_front.sv
module mkde_front
   import mkde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         q_full,
   output logic         q_push,
   output scan_ev_type  q_data
);

   logic [CNT_W-1:0] cnt_ff [KEY_TOTAL];
   logic [CNT_W-1:0] cnt_in [KEY_TOTAL];
   logic [KEY_W-1:0] key   [SCAN_COLS];
   logic [CNT_W-1:0] nxt   [SCAN_COLS];
   logic             upd;
   scan_ev_type      ev;

   assign req_ready = !q_full;
   assign upd = req_valid && req_ready && cfg.enabled
                && ({1'b0, req_word.row_index} < 3'(ROWS));

   always_comb begin
      logic [CNT_W-1:0] c;
      logic [CNT_W-1:0] inc;
      ev.row     = req_word.row_index;
      ev.ev_mask = '0;
      ev.codes   = '0;
      for (int j = 0; j < SCAN_COLS; j++) begin
         key[j] = KEY_W'(int'(req_word.row_index) * COLUMNS + j);
         c      = cnt_ff[key[j]];
         inc    = (c == CNT_MAX) ? c : c + 8'd1;
         if (req_word.column_levels[j]) begin
            // released: report if the press had been seen
            nxt[j] = '0;
            if (c >= cfg.debounce_count) begin
               ev.ev_mask[j] = 1'b1;
               ev.codes[j]   = EV_RELEASE;
            end
         end else begin
            nxt[j] = inc;
            if (inc == cfg.debounce_count) begin
               ev.ev_mask[j] = 1'b1;
               ev.codes[j]   = EV_PRESS;
            end else if (inc == cfg.longpress_count) begin
               ev.ev_mask[j] = 1'b1;
               ev.codes[j]   = EV_LONG;
            end
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (upd) begin
         for (int j = 0; j < SCAN_COLS; j++) begin
            cnt_in[key[j]] = nxt[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_TOTAL; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign q_push = upd && (ev.ev_mask != '0);
   assign q_data = ev;

endmodule

FILE: rtl/mkde_queue.sv
module mkde_queue
   import mkde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  scan_ev_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output scan_ev_type head_data
);

   scan_ev_type mem [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/mkde_back.sv
module mkde_back
   import mkde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  scan_ev_type  head_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic [SCAN_COLS-1:0] done_ff, done_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic [SCAN_COLS-1:0] pend;
   logic [SCAN_COLS-1:0] pick;
   logic [1:0]           pick_col;
   logic                 last;
   logic                 load;

   assign pend = head_data.ev_mask & ~done_ff;

   // lowest pending column goes first
   always_comb begin
      pick     = '0;
      pick_col = '0;
      for (int j = SCAN_COLS - 1; j >= 0; j--) begin
         if (pend[j]) begin
            pick     = SCAN_COLS'(1) << j;
            pick_col = 2'(j);
         end
      end
   end

   assign last = ((pend & ~pick) == '0);
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && last;

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (load) begin
         rsp_valid_in           = 1'b1;
         rsp_word_in.key_index  = KEY_W'(int'(head_data.row) * COLUMNS + int'(pick_col));
         rsp_word_in.event_code = head_data.codes[pick_col];
         rsp_word_in.last_event = last;
         done_in                = last ? '0 : (done_ff | pick);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

FILE: rtl/matrix_keypad_debounce_events_top.sv
// an accepted scan word is classified and queued, then its events enter the output
// register from the queue head; scan words are taken one per cycle while the queue is
// not full; the event serializer (one event per cycle while rsp_ready is high) sets
// the rate, a 2-deep queue decouples it; reset (synchronous, active high) clears all
// key counters, the queue and rsp_valid, and sets enabled 0, debounce 3, long press 100
module matrix_keypad_debounce_events_top
   import mkde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // scan word in
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_word_type         req_word,
   // event word out
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_word_type         rsp_word,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_full;
   logic        q_push;
   scan_ev_type q_data;
   logic        q_pop;
   logic        q_head_valid;
   scan_ev_type q_head_data;

   // config registers, unknown index is dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED:   cfg_in.enabled         = csr_wdata[0];
            CSR_DEBOUNCE:  cfg_in.debounce_count  = csr_wdata;
            CSR_LONGPRESS: cfg_in.longpress_count = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled         <= 1'b0;
         cfg_ff.debounce_count  <= 8'd3;
         cfg_ff.longpress_count <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: counter update and event classification for the whole row
   mkde_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // rows with at least one event wait here
   mkde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // back: one event per cycle, ascending column, into the output register unless stalled
   mkde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

FILE: tb/matrix_keypad_debounce_events_top_test.sv
module matrix_keypad_debounce_events_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mkde_pkg::*;

   // index with no register behind it, writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // cycles to let pass after the last event before touching registers or ending
   localparam int DRAIN_CYCLES = 8;
   // keep a wide margin over the slowest run
   localparam int CYCLE_LIMIT  = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_word_type         req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   matrix_keypad_debounce_events_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // scan words waiting for the driver, and the events they should cause
   req_word_type     scan_backlog[$];
   rsp_word_type     pending_events[$];

   // local copy of the key counters and registers
   logic [CNT_W-1:0] key_count [KEY_TOTAL];
   logic             model_enabled;
   logic [CNT_W-1:0] model_debounce;
   logic [CNT_W-1:0] model_longpress;

   // which keys the random sequences currently hold down, per row
   logic [IN_COLS-1:0] held_cols [ROWS];

   int  words_queued = 0;
   int  words_sent   = 0;
   int  error_count  = 0;
   int  cycle_count  = 0;
   int  gap_left     = 0;
   int  stall_left   = 0;
   bit  tx_idle_on   = 1'b1;
   bit  rx_idle_on   = 1'b1;
   bit  req_took     = 1'b0;

   // mostly short pauses, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // events one row scan causes, in column order, last one flagged
   task automatic debounce_row(input req_word_type w);
      rsp_word_type     ev;
      rsp_word_type     found[$];
      logic [CNT_W-1:0] c;
      logic [1:0]       code;
      logic             fire;
      int               key;
      // disabled block or a row beyond the matrix leaves everything alone
      if (!model_enabled) return;
      if (int'(w.row_index) >= ROWS) return;
      for (int j = 0; j < SCAN_COLS; j++) begin
         key  = int'(w.row_index) * COLUMNS + j;
         c    = key_count[key];
         fire = 1'b0;
         code = EV_PRESS;
         if (w.column_levels[j]) begin
            // released column: report only if the key had been debounced
            if (c >= model_debounce) begin
               fire = 1'b1;
               code = EV_RELEASE;
            end
            key_count[key] = '0;
         end else begin
            // held column: count up, stick at the top
            if (c != CNT_MAX) c = c + 8'd1;
            key_count[key] = c;
            // press wins when both thresholds match
            if (c == model_debounce) begin
               fire = 1'b1;
               code = EV_PRESS;
            end else if (c == model_longpress) begin
               fire = 1'b1;
               code = EV_LONG;
            end
         end
         if (fire) begin
            ev.key_index  = KEY_W'(key);
            ev.event_code = code;
            ev.last_event = 1'b0;
            found.push_back(ev);
         end
      end
      foreach (found[i]) begin
         ev = found[i];
         ev.last_event = (i == found.size() - 1);
         pending_events.push_back(ev);
      end
   endtask

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      req_took = 1'b0;
      if (reset) begin
         for (int k = 0; k < KEY_TOTAL; k++) key_count[k] = '0;
         model_enabled   = 1'b0;
         model_debounce  = 8'd3;
         model_longpress = 8'd100;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLED:   model_enabled   = csr_wdata[0];
               CSR_DEBOUNCE:  model_debounce  = csr_wdata;
               CSR_LONGPRESS: model_longpress = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            req_took = 1'b1;
            words_sent++;
            debounce_row(req_word);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $display("%0t: event word with none expected, actual key %0d code %0d last %0b",
                        $time, rsp_word.key_index, rsp_word.event_code, rsp_word.last_event);
               error_count++;
            end else begin
               rsp_word_type want;
               want = pending_events.pop_front();
               if (rsp_word.key_index !== want.key_index) begin
                  $display("%0t: key_index expected %0d actual %0d",
                           $time, want.key_index, rsp_word.key_index);
                  error_count++;
               end
               if (rsp_word.event_code !== want.event_code) begin
                  $display("%0t: event_code expected %0d actual %0d",
                           $time, want.event_code, rsp_word.event_code);
                  error_count++;
               end
               if (rsp_word.last_event !== want.last_event) begin
                  $display("%0t: last_event expected %0b actual %0b",
                           $time, want.last_event, rsp_word.last_event);
                  error_count++;
               end
            end
         end
      end
   end

   // scan word driver, changes only at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (scan_backlog.size() != 0) begin
            req_word  <= scan_backlog.pop_front();
            req_valid <= 1'b1;
            // idle time taken once this word is gone
            if (tx_idle_on && $urandom_range(0, 99) < 35) gap_left = pick_gap();
            else gap_left = 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // event receiver, stalls at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rx_idle_on && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d events still expected", $time, pending_events.size());
         $display("matrix_keypad_debounce_events_top regression: fail");
         $finish;
      end
   end

   task automatic push_scan(input int row, input logic [IN_COLS-1:0] levels);
      req_word_type w;
      w.row_index     = ROW_W'(row);
      w.column_levels = levels;
      scan_backlog.push_back(w);
      words_queued++;
   endtask

   // every word taken and every event seen, then some quiet cycles
   task automatic wait_drained(input int extra);
      do @(negedge clock);
      while (words_sent != words_queued || pending_events.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_config(input logic en, input logic [CNT_W-1:0] deb,
                             input logic [CNT_W-1:0] lng);
      wait_drained(DRAIN_CYCLES);
      write_reg(CSR_ENABLED, {7'd0, en});
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_LONGPRESS, lng);
   endtask

   // keys pressed and held for a while with random content, some bounce noise,
   // pinned columns stay low the whole phase, the sender pauses halfway
   task automatic scan_phase(input int count, input int fixed_row,
                             input logic [IN_COLS-1:0] pinned);
      int                 row;
      logic [IN_COLS-1:0] levels;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_drained(0);
         row = (fixed_row >= 0) ? fixed_row : $urandom_range(0, ROWS - 1);
         if ($urandom_range(0, 99) < 12) begin
            levels = IN_COLS'($urandom_range(0, 15)) & ~pinned;
         end else begin
            for (int j = 0; j < IN_COLS; j++) begin
               if ($urandom_range(0, 99) < 12) held_cols[row][j] = ~held_cols[row][j];
            end
            levels = ~(held_cols[row] | pinned);
         end
         push_scan(row, levels);
      end
   endtask

   initial begin
      for (int r = 0; r < ROWS; r++) held_cols[r] = '0;

      // reset once, released at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: scans change nothing
      push_scan(0, 4'h0);
      push_scan(3, 4'hF);
      wait_drained(DRAIN_CYCLES);
      // write to a missing register is dropped, block stays disabled
      write_reg(CSR_UNUSED, 8'hFF);
      push_scan(2, 4'h0);

      // short thresholds so a few scans give press, long press and release
      set_config(1'b1, 8'd2, 8'd3);
      push_scan(1, 4'h0);
      push_scan(1, 4'h0);
      push_scan(1, 4'h0);
      push_scan(1, 4'hA);
      // single column held per scan
      push_scan(2, 4'hE);
      push_scan(2, 4'hD);
      push_scan(2, 4'hB);
      push_scan(2, 4'h7);
      push_scan(0, 4'hF);

      // zero debounce: every released column reports, even from zero
      wait_drained(DRAIN_CYCLES);
      write_reg(CSR_DEBOUNCE, 8'd0);
      push_scan(0, 4'hF);
      push_scan(3, 4'h0);

      // equal thresholds: press only
      wait_drained(DRAIN_CYCLES);
      write_reg(CSR_DEBOUNCE, 8'd2);
      write_reg(CSR_LONGPRESS, 8'd2);
      push_scan(3, 4'h0);
      push_scan(3, 4'h0);
      push_scan(3, 4'h0);
      push_scan(3, 4'hF);

      // random part, one setting per phase
      set_config(1'b1, 8'd3, 8'd100);
      scan_phase(12, -1, 4'h0);

      // no idling on either side here
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_config(1'b1, 8'd0, 8'd255);
      scan_phase(10, -1, 4'h0);

      tx_idle_on = 1'b1;
      set_config(1'b1, 8'd4, 8'd4);
      scan_phase(10, -1, 4'h0);

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      set_config(1'b1, 8'd1, 8'd0);
      scan_phase(10, -1, 4'h0);

      // one key held long enough to saturate, press then repeats every scan
      tx_idle_on = 1'b1;
      set_config(1'b1, 8'd255, 8'd2);
      scan_phase(260, 2, 4'h1);

      // disabled again for a few scans
      set_config(1'b0, 8'd3, 8'd6);
      scan_phase(4, -1, 4'h0);

      set_config(1'b1, 8'($urandom_range(1, 6)), 8'($urandom_range(5, 20)));
      scan_phase(10, -1, 4'h0);

      wait_drained(DRAIN_CYCLES);
      if (pending_events.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("matrix_keypad_debounce_events_top regression: pass");
      end else begin
         $display("matrix_keypad_debounce_events_top regression: fail");
      end
      $finish;
   end

endmodule
